[hw/rtl/tpr_pkg.sv]
`timescale 1ns / 1ps

package tpr_pkg;

	// One request as it arrives on the input channel.
	typedef struct packed {
		logic [9:0]         pixel;
		logic signed [31:0] sample;
		logic               missing;
		logic [31:0]        time_stamp;
		logic               first_step;
		logic               last_step;
	} tpr_in_t;

	// One finished result.
	typedef struct packed {
		logic [9:0]         pixel_out;
		logic signed [63:0] result;
		logic               no_value;
		logic               saturated;
	} tpr_out_t;

	// Classified request handed from the front to the back through the queue.
	typedef struct packed {
		logic [9:0]  pixel;
		logic [31:0] sample;
		logic [31:0] time_stamp;
		logic        clear;
		logic        comb;
		logic        emit;
	} tpr_cmd_t;

	// Operations of the shared iterative arithmetic unit.
	typedef enum logic [1:0] {
		OP_DIV   = 2'd0,
		OP_MUL16 = 2'd1,
		OP_MUL48 = 2'd2,
		OP_SQRT  = 2'd3
	} tpr_op_t;

	// Statistic codes of the mode register.
	localparam logic [3:0] MODE_SUM   = 4'd0;
	localparam logic [3:0] MODE_PROD  = 4'd1;
	localparam logic [3:0] MODE_MEAN  = 4'd2;
	localparam logic [3:0] MODE_MIN   = 4'd3;
	localparam logic [3:0] MODE_MAX   = 4'd4;
	localparam logic [3:0] MODE_COUNT = 4'd5;
	localparam logic [3:0] MODE_VAR   = 4'd6;
	localparam logic [3:0] MODE_SD    = 4'd7;
	localparam logic [3:0] MODE_TMIN  = 4'd8;
	localparam logic [3:0] MODE_TMAX  = 4'd9;

	localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAXPOS64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_Q16  = 64'h0000_0000_0001_0000;

	// Per-pixel state word: clip flag, count, auxiliary, accumulator.
	localparam int STATE_W = 1 + 16 + 64 + 64;

endpackage

[hw/rtl/temporal_pixel_reducer_unit.sv]
`timescale 1ns / 1ps

// Per-pixel time-series reducer. Each request names a pixel and carries one
// Q16.16 sample; first_step clears that pixel's state, last_step returns its
// statistic (selected by the mode register) as one result. The front queues
// up to four requests and keeps accepting while the back works and while a
// finished result waits in the output register. The back does one
// read-modify-write of the per-pixel state memory per request; product,
// variance and sd modes use the bit-serial shared multiply/divide/root
// unit. A mean or variance result adds a divide by that unit, and sd a
// further square root.
// The state memory is not cleared after reset; every series must begin with
// first_step.
module temporal_pixel_reducer_unit import tpr_pkg::*; #(
	parameter int PIXELS = 1024,
	parameter int MAX_STEPS = 65535
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode_we,
	input  logic [3:0] mode_wdata,
	input  logic       req_valid,
	output logic       req_ready,
	input  tpr_in_t    req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output tpr_out_t   rsp
);

	logic [3:0] mode_q;
	logic       cmd_valid;
	logic       cmd_pop;
	tpr_cmd_t   cmd;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SUM;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	tpr_front #(
		.PIXELS (PIXELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	tpr_back #(
		.PIXELS    (PIXELS),
		.MAX_STEPS (MAX_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[hw/rtl/tpr_ram.sv]
`timescale 1ns / 1ps

module tpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/tpr_front.sv]
`timescale 1ns / 1ps

module tpr_front import tpr_pkg::*; #(
	parameter int PIXELS = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  tpr_in_t  req,
	output logic     cmd_valid,
	input  logic     cmd_pop,
	output tpr_cmd_t cmd
);

	tpr_cmd_t   fifo_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       push;
	logic       in_range;
	tpr_cmd_t   cmd_new;

	// Requests for pixels outside the array are dropped at the door.
	assign in_range = {7'd0, req.pixel} < 17'(PIXELS);
	assign req_ready = (count_q != 3'd4);
	assign push = req_valid && req_ready && in_range;

	// Classify the request into clear, combine and emit actions.
	always_comb begin
		cmd_new.pixel      = req.pixel;
		cmd_new.sample     = req.sample;
		cmd_new.time_stamp = req.time_stamp;
		cmd_new.clear      = req.first_step;
		cmd_new.comb       = !req.missing;
		cmd_new.emit       = req.last_step;
	end

	assign cmd_valid = (count_q != 3'd0);
	assign cmd = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_new;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 3'd1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 3'd1;
			end
		end
	end

endmodule

[hw/rtl/tpr_arith.sv]
`timescale 1ns / 1ps

module tpr_arith import tpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  tpr_op_t     op,
	input  logic [63:0] opa,
	input  logic [63:0] opb,
	output logic        done,
	output logic [63:0] res,
	output logic        ovf
);

	logic          busy_q;
	logic          done_q;
	tpr_op_t       op_q;
	logic [6:0]    cnt_q;
	logic [127:0]  prod_q;
	logic [127:0]  mcand_q;
	logic [63:0]   mplier_q;
	logic [63:0]   quo_q;
	logic [16:0]   rem_q;
	logic [15:0]   dvs_q;
	logic [79:0]   rad_q;
	logic [41:0]   srem_q;
	logic [39:0]   root_q;

	logic [16:0]   div_r2;
	logic          div_ge;
	logic [43:0]   sq_r2;
	logic [41:0]   sq_trial;
	logic          sq_ge;
	logic [127:0]  mul_rnd;
	logic [127:0]  mul_shr;
	logic [16:0]   div_half;
	logic          div_up;

	// One restoring-division step.
	assign div_r2 = {rem_q[15:0], quo_q[63]};
	assign div_ge = div_r2 >= {1'b0, dvs_q};

	// One digit-by-digit square-root step.
	assign sq_r2    = {srem_q, rad_q[79:78]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge    = sq_r2 >= {2'b00, sq_trial};

	// Final rounding of the product and the quotient.
	assign mul_rnd  = prod_q + ((op_q == OP_MUL16) ? (128'd1 << 15) : (128'd1 << 47));
	assign mul_shr  = (op_q == OP_MUL16) ? (mul_rnd >> 16) : (mul_rnd >> 48);
	assign div_half = {1'b0, dvs_q} - rem_q;
	assign div_up   = rem_q >= div_half;

	always_comb begin
		case (op_q)
			OP_DIV: begin
				res = quo_q + {63'd0, div_up};
				ovf = 1'b0;
			end
			OP_MUL16, OP_MUL48: begin
				res = mul_shr[63:0];
				ovf = |mul_shr[127:64];
			end
			OP_SQRT: begin
				res = {24'd0, root_q};
				ovf = 1'b0;
			end
			default: begin
				res = 64'd0;
				ovf = 1'b0;
			end
		endcase
	end

	assign done = done_q;

	// Sequencing: one bit of multiplier or quotient, or one root digit, per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_DIV;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 7'd1);
			if (start) begin
				busy_q <= 1'b1;
				op_q   <= op;
				cnt_q  <= (op == OP_SQRT) ? 7'd40 : 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q   <= 128'd0;
			mcand_q  <= {64'd0, opa};
			mplier_q <= opb;
			quo_q    <= opa;
			rem_q    <= 17'd0;
			dvs_q    <= opb[15:0];
			rad_q    <= {opa, 16'd0};
			srem_q   <= 42'd0;
			root_q   <= 40'd0;
		end else if (busy_q) begin
			case (op_q)
				OP_MUL16, OP_MUL48: begin
					if (mplier_q[0]) begin
						prod_q <= prod_q + mcand_q;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
				OP_DIV: begin
					rem_q <= div_ge ? (div_r2 - {1'b0, dvs_q}) : div_r2;
					quo_q <= {quo_q[62:0], div_ge};
				end
				OP_SQRT: begin
					srem_q <= sq_ge ? 42'(sq_r2 - {2'b00, sq_trial}) : sq_r2[41:0];
					root_q <= {root_q[38:0], sq_ge};
					rad_q  <= rad_q << 2;
				end
				default: begin
					prod_q <= prod_q;
				end
			endcase
		end
	end

endmodule

[hw/rtl/tpr_back.sv]
`timescale 1ns / 1ps

module tpr_back import tpr_pkg::*; #(
	parameter int PIXELS = 1024,
	parameter int MAX_STEPS = 65535
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic [3:0] mode,
	input  logic     cmd_valid,
	output logic     cmd_pop,
	input  tpr_cmd_t cmd,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output tpr_out_t rsp
);

	localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam logic [15:0] MAX_CNT = 16'(MAX_STEPS);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_LOAD  = 12'b0000_0000_0010,
		S_COMB  = 12'b0000_0000_0100,
		S_PMUL  = 12'b0000_0000_1000,
		S_VDIV  = 12'b0000_0001_0000,
		S_VMUL0 = 12'b0000_0010_0000,
		S_VMUL  = 12'b0000_0100_0000,
		S_WB    = 12'b0000_1000_0000,
		S_FIN   = 12'b0001_0000_0000,
		S_FDIV  = 12'b0010_0000_0000,
		S_SQRT  = 12'b0100_0000_0000,
		S_EMIT  = 12'b1000_0000_0000
	} tpr_state_t;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// Returns {clip, sum}.
	function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if ((a[63] == b[63]) && (r[63] != a[63])) begin
			return {1'b1, a[63] ? SIGN64 : MAXPOS64};
		end
		return {1'b0, r};
	endfunction

	// Returns {clip, value} for a magnitude and a sign.
	function automatic logic [64:0] from_mag(input logic [63:0] m, input logic neg);
		if (neg) begin
			if (m > SIGN64) begin
				return {1'b1, SIGN64};
			end
			return {1'b0, ~m + 64'd1};
		end
		if (m > MAXPOS64) begin
			return {1'b1, MAXPOS64};
		end
		return {1'b0, m};
	endfunction

	tpr_state_t  state_q;
	tpr_cmd_t    cmd_q;
	logic [63:0] acc_q;
	logic [63:0] aux_q;
	logic [15:0] cnt_q;
	logic        clip_q;
	logic [63:0] delta_q;
	logic        neg_q;
	logic [63:0] res_q;
	logic        none_q;
	logic        rsp_valid_q;
	tpr_out_t    rsp_q;

	logic [STATE_W-1:0] ram_rdata;
	logic [STATE_W-1:0] ram_wdata;
	logic               ram_we;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [AW-1:0]      ram_waddr;
	logic [15:0]        pix_rd;
	logic [15:0]        pix_wr;

	logic        ar_start;
	tpr_op_t     ar_op;
	logic [63:0] ar_opa;
	logic [63:0] ar_opb;
	logic        ar_done;
	logic [63:0] ar_res;
	logic        ar_ovf;

	logic [63:0] xv;
	logic [63:0] xq;
	logic [63:0] d2;
	logic        cnt_full;
	logic [15:0] cnt_nxt;
	logic [64:0] add_x;
	logic [64:0] mul_v;
	logic [64:0] mul_acc;
	logic [63:0] div_v;
	logic        emit_free;
	logic        need_arith;
	logic        fin_div;

	assign xv       = {{32{cmd_q.sample[31]}}, cmd_q.sample};
	assign xq       = xv << 16;
	assign d2       = xq - aux_q;
	assign cnt_full = cnt_q >= MAX_CNT;
	assign cnt_nxt  = cnt_full ? MAX_CNT : (cnt_q + 16'd1);
	assign add_x    = sat_add(acc_q, xv);
	assign mul_v    = ar_ovf ? {1'b1, neg_q ? SIGN64 : MAXPOS64} : from_mag(ar_res, neg_q);
	assign mul_acc  = sat_add(acc_q, mul_v[63:0]);
	assign div_v    = acc_q[63] ? (~ar_res + 64'd1) : ar_res;
	assign emit_free = !rsp_valid_q || rsp_ready;

	assign need_arith = (mode == MODE_PROD) || (mode == MODE_VAR) || (mode == MODE_SD);
	assign fin_div = ((mode == MODE_MEAN) && (cnt_q != 16'd0)) ||
		(((mode == MODE_VAR) || (mode == MODE_SD)) && (cnt_q >= 16'd2));

	// State memory: one word per pixel, read-modify-write per request.
	assign pix_rd    = {6'd0, cmd.pixel};
	assign pix_wr    = {6'd0, cmd_q.pixel};
	assign ram_raddr = pix_rd[AW-1:0];
	assign ram_waddr = pix_wr[AW-1:0];
	assign ram_re    = (state_q == S_IDLE) && cmd_valid;
	assign ram_we    = (state_q == S_WB);
	assign ram_wdata = {clip_q, cnt_q, aux_q, acc_q};
	assign cmd_pop   = ram_re;

	tpr_ram #(
		.WIDTH (STATE_W),
		.DEPTH (PIXELS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Requests to the shared arithmetic unit.
	always_comb begin
		ar_start = 1'b0;
		ar_op    = OP_DIV;
		ar_opa   = mag64(acc_q);
		ar_opb   = {48'd0, cnt_q};
		case (state_q)
			S_COMB: begin
				ar_start = cmd_q.comb && need_arith;
				if (mode == MODE_PROD) begin
					ar_op  = OP_MUL16;
					ar_opa = mag64(acc_q);
					ar_opb = mag64(xv);
				end else begin
					ar_op  = OP_DIV;
					ar_opa = mag64(xq - aux_q);
					ar_opb = {48'd0, cnt_nxt};
				end
			end
			S_VMUL0: begin
				ar_start = 1'b1;
				ar_op    = OP_MUL48;
				ar_opa   = mag64(delta_q);
				ar_opb   = mag64(d2);
			end
			S_FIN: begin
				ar_start = fin_div;
				ar_op    = OP_DIV;
				ar_opa   = mag64(acc_q);
				ar_opb   = (mode == MODE_MEAN) ? {48'd0, cnt_q} : {48'd0, cnt_q - 16'd1};
			end
			S_FDIV: begin
				ar_start = ar_done && (mode == MODE_SD) && !div_v[63];
				ar_op    = OP_SQRT;
				ar_opa   = div_v;
				ar_opb   = 64'd0;
			end
			default: begin
				ar_start = 1'b0;
			end
		endcase
	end

	tpr_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ar_start),
		.op     (ar_op),
		.opa    (ar_opa),
		.opb    (ar_opb),
		.done   (ar_done),
		.res    (ar_res),
		.ovf    (ar_ovf)
	);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_EMIT) && emit_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_COMB;
				end
				S_COMB: begin
					if (!cmd_q.comb) begin
						state_q <= S_WB;
					end else if (mode == MODE_PROD) begin
						state_q <= S_PMUL;
					end else if ((mode == MODE_VAR) || (mode == MODE_SD)) begin
						state_q <= S_VDIV;
					end else begin
						state_q <= S_WB;
					end
				end
				S_PMUL: begin
					if (ar_done) begin
						state_q <= S_WB;
					end
				end
				S_VDIV: begin
					if (ar_done) begin
						state_q <= S_VMUL0;
					end
				end
				S_VMUL0: begin
					state_q <= S_VMUL;
				end
				S_VMUL: begin
					if (ar_done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					state_q <= cmd_q.emit ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					state_q <= fin_div ? S_FDIV : S_EMIT;
				end
				S_FDIV: begin
					if (ar_done) begin
						state_q <= ar_start ? S_SQRT : S_EMIT;
					end
				end
				S_SQRT: begin
					if (ar_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working copy of the pixel state and the result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
			end
			S_LOAD: begin
				if (cmd_q.clear) begin
					acc_q  <= (mode == MODE_PROD) ? ONE_Q16 : 64'd0;
					aux_q  <= 64'd0;
					cnt_q  <= 16'd0;
					clip_q <= 1'b0;
				end else begin
					acc_q  <= ram_rdata[63:0];
					aux_q  <= ram_rdata[127:64];
					cnt_q  <= ram_rdata[143:128];
					clip_q <= ram_rdata[144];
				end
			end
			S_COMB: begin
				if (cmd_q.comb) begin
					cnt_q <= cnt_nxt;
					// The count clips at its ceiling; sums clip at the 64-bit range.
					if (cnt_full || (((mode == MODE_SUM) || (mode == MODE_MEAN)) &&
						add_x[64])) begin
						clip_q <= 1'b1;
					end
					neg_q   <= (mode == MODE_PROD) ? (acc_q[63] ^ xv[63]) : neg_q;
					delta_q <= xq - aux_q;
					case (mode)
						MODE_SUM, MODE_MEAN: begin
							acc_q <= add_x[63:0];
						end
						MODE_MIN, MODE_TMIN: begin
							if ((cnt_q == 16'd0) || ($signed(xv) < $signed(acc_q))) begin
								acc_q <= xv;
								aux_q <= {32'd0, cmd_q.time_stamp};
							end
						end
						MODE_MAX, MODE_TMAX: begin
							if ((cnt_q == 16'd0) || ($signed(acc_q) < $signed(xv))) begin
								acc_q <= xv;
								aux_q <= {32'd0, cmd_q.time_stamp};
							end
						end
						default: begin
							acc_q <= acc_q;
						end
					endcase
				end
			end
			S_PMUL: begin
				if (ar_done) begin
					acc_q <= mul_v[63:0];
					if (mul_v[64]) begin
						clip_q <= 1'b1;
					end
				end
			end
			S_VDIV: begin
				if (ar_done) begin
					aux_q <= delta_q[63] ? (aux_q - ar_res) : (aux_q + ar_res);
				end
			end
			S_VMUL0: begin
				neg_q <= delta_q[63] ^ d2[63];
			end
			S_VMUL: begin
				if (ar_done) begin
					acc_q <= mul_acc[63:0];
					if (mul_v[64] || mul_acc[64]) begin
						clip_q <= 1'b1;
					end
				end
			end
			S_FIN: begin
				case (mode)
					MODE_SUM, MODE_PROD: begin
						res_q  <= acc_q;
						none_q <= 1'b0;
					end
					MODE_COUNT: begin
						res_q  <= {48'd0, cnt_q};
						none_q <= 1'b0;
					end
					MODE_MEAN, MODE_MIN, MODE_MAX: begin
						res_q  <= acc_q;
						none_q <= (cnt_q == 16'd0);
					end
					MODE_TMIN, MODE_TMAX: begin
						res_q  <= {32'd0, aux_q[31:0]};
						none_q <= (cnt_q == 16'd0);
					end
					MODE_VAR, MODE_SD: begin
						res_q  <= 64'd0;
						none_q <= (cnt_q < 16'd2);
					end
					default: begin
						res_q  <= 64'd0;
						none_q <= 1'b1;
					end
				endcase
			end
			S_FDIV: begin
				if (ar_done) begin
					res_q <= ((mode == MODE_SD) && div_v[63]) ? 64'd0 : div_v;
				end
			end
			S_SQRT: begin
				if (ar_done) begin
					res_q <= ar_res;
				end
			end
			S_EMIT: begin
				if (emit_free) begin
					rsp_q.pixel_out <= cmd_q.pixel;
					rsp_q.result    <= none_q ? 64'sd0 : $signed(res_q);
					rsp_q.no_value  <= none_q;
					rsp_q.saturated <= clip_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hw/rtl/tpr_checker.sv]
`timescale 1ns / 1ps

module tpr_checker import tpr_pkg::*; #(
	parameter int PIXELS = 1024
) (
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input tpr_out_t rsp
);

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// An undefined statistic reads as zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.no_value |-> rsp.result == 64'sd0)
		else $error("no_value result is not zero");

	// Results only name pixels that exist.
	a_pixel_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> {7'd0, rsp.pixel_out} < 17'(PIXELS))
		else $error("result for a pixel out of range");

endmodule

bind temporal_pixel_reducer_unit tpr_checker #(
	.PIXELS (PIXELS)
) u_tpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
